// File: hdl/lzss_pkg.sv
package lzss_pkg;

    // Ring geometry
    localparam int RING_AW   = 12;
    localparam int LOOKAHEAD = 18;
    localparam int FILL_W    = RING_AW + 1;
    localparam logic [RING_AW-1:0] RING_START = RING_AW'((1 << RING_AW) - LOOKAHEAD);

    // Token lengths and byte counts
    localparam int LEN_W = 5;
    localparam logic [LEN_W-1:0] MIN_MATCH = LEN_W'(3);
    localparam int CNT_W = 29;
    localparam logic [CNT_W-1:0] SIZE_CAP = CNT_W'(32'h1000_0000);

    // Fill bytes of a fresh ring
    localparam logic [7:0] SPACE_BYTE = 8'h20;
    localparam logic [7:0] ZERO_BYTE  = 8'h00;

    // Command queue
    localparam int FIFO_AW = 2;

    // Command kinds
    localparam logic [1:0] CMD_NONE  = 2'd0;
    localparam logic [1:0] CMD_LIT   = 2'd1;
    localparam logic [1:0] CMD_MATCH = 2'd2;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_input;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       stream_done;
        logic       status;
    } out_item_t;

    typedef struct packed {
        logic [1:0]         kind;
        logic [7:0]         data;
        logic [RING_AW-1:0] pos;
        logic [LEN_W-1:0]   len;
        logic               eoi;
    } cmd_t;

    typedef struct packed {
        logic idle;
        logic err_load;
        logic fresh;
    } back_stat_t;

endpackage

// File: hdl/lzss_front.sv
module lzss_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  lzss_pkg::in_item_t s_data,
    output logic               cmd_push,
    output lzss_pkg::cmd_t     cmd,
    input  logic               fifo_full
);
    import lzss_pkg::*;

    localparam logic [1:0] PH_FLAG  = 2'd0;
    localparam logic [1:0] PH_TOKEN = 2'd1;
    localparam logic [1:0] PH_HIGH  = 2'd2;

    logic [1:0] phase_reg, phase_next;
    logic [7:0] flags_reg, flags_next;
    logic [3:0] left_reg, left_next;
    logic [7:0] low_reg, low_next;
    logic       accept;
    logic [3:0] left_dec;
    logic [1:0] phase_adv;

    assign s_ready = !fifo_full;
    assign accept  = s_valid && s_ready;

    // Step to the next flag bit
    assign left_dec  = (left_reg != 4'd0) ? left_reg - 4'd1 : left_reg;
    assign phase_adv = (left_dec != 4'd0) ? PH_TOKEN : PH_FLAG;

    // Classify each transfer into a command
    always_comb begin
        phase_next = phase_reg;
        flags_next = flags_reg;
        left_next  = left_reg;
        low_next   = low_reg;
        cmd.kind   = CMD_NONE;
        cmd.data   = s_data.in_byte;
        cmd.pos    = {s_data.in_byte[7:4], low_reg};
        cmd.len    = {1'b0, s_data.in_byte[3:0]} + MIN_MATCH;
        cmd.eoi    = s_data.end_of_input;
        if (accept) begin
            case (phase_reg)
                PH_FLAG: begin
                    flags_next = s_data.in_byte;
                    left_next  = 4'd8;
                    phase_next = PH_TOKEN;
                end
                PH_TOKEN: begin
                    if (flags_reg[0]) begin
                        cmd.kind   = CMD_LIT;
                        cmd.len    = LEN_W'(1);
                        flags_next = {1'b0, flags_reg[7:1]};
                        left_next  = left_dec;
                        phase_next = phase_adv;
                    end else begin
                        low_next   = s_data.in_byte;
                        phase_next = PH_HIGH;
                    end
                end
                PH_HIGH: begin
                    cmd.kind   = CMD_MATCH;
                    flags_next = {1'b0, flags_reg[7:1]};
                    left_next  = left_dec;
                    phase_next = phase_adv;
                end
                default: begin
                    phase_next = PH_FLAG;
                end
            endcase
            // Restart parsing after the last byte of a stream
            if (s_data.end_of_input) begin
                phase_next = PH_FLAG;
                flags_next = 8'd0;
                left_next  = 4'd0;
                low_next   = 8'd0;
            end
        end
    end

    // Queue only commands that can cause results
    assign cmd_push = accept && ((cmd.kind != CMD_NONE) || s_data.end_of_input);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_FLAG;
            flags_reg <= 8'd0;
            left_reg  <= 4'd0;
            low_reg   <= 8'd0;
        end else begin
            phase_reg <= phase_next;
            flags_reg <= flags_next;
            left_reg  <= left_next;
            low_reg   <= low_next;
        end
    end

endmodule

// File: hdl/lzss_cmd_fifo.sv
module lzss_cmd_fifo (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  lzss_pkg::cmd_t push_cmd,
    output logic           full,
    input  logic           pop,
    output lzss_pkg::cmd_t pop_cmd,
    output logic           empty
);
    import lzss_pkg::*;

    localparam int DEPTH = 1 << FIFO_AW;

    cmd_t               slot_reg [DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_AW:0]   count_reg, count_next;
    logic               do_push, do_pop;

    assign full    = (count_reg == (FIFO_AW+1)'(DEPTH));
    assign empty   = (count_reg == '0);
    assign pop_cmd = slot_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    // Advance pointers and occupancy
    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + FIFO_AW'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + FIFO_AW'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + (FIFO_AW+1)'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - (FIFO_AW+1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the entry
    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// File: hdl/lzss_back.sv
module lzss_back (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic [lzss_pkg::CNT_W-1:0]     limit,
    input  logic                           cmd_empty,
    input  lzss_pkg::cmd_t                 cmd,
    output logic                           cmd_pop,
    output logic                           m_valid,
    input  logic                           m_ready,
    output lzss_pkg::out_item_t            m_data,
    output lzss_pkg::back_stat_t           stat
);
    import lzss_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_ERR  = 2'd2;

    // History ring
    logic [7:0] ring_mem [1 << RING_AW];
    logic [7:0] mem_rdata_reg;

    logic [1:0]         st_reg, st_next;
    logic               lit_reg, lit_next;
    logic [7:0]         lit_byte_reg, lit_byte_next;
    logic [RING_AW-1:0] rd_addr_reg, rd_addr_next;
    logic [LEN_W-1:0]   left_reg, left_next;
    logic               eoi_reg, eoi_next;
    logic               d_valid_reg, d_valid_next;
    logic               d_last_reg, d_last_next;
    logic               d_hit_reg, d_hit_next;
    logic [7:0]         d_hit_data_reg, d_hit_data_next;
    logic               d_written_reg, d_written_next;
    logic [7:0]         d_dflt_reg, d_dflt_next;
    logic [RING_AW-1:0] cursor_reg, cursor_next;
    logic [FILL_W-1:0]  fill_reg, fill_next;
    logic [CNT_W-1:0]   emitted_reg, emitted_next;
    logic               finished_reg, finished_next;
    logic               m_valid_reg, m_valid_next;
    out_item_t          m_data_reg, m_data_next;

    logic               o_free;
    logic               emit;
    logic               issue;
    logic               done;
    logic               precheck_fin;
    logic               err_load;
    logic [7:0]         emit_byte;
    logic [CNT_W-1:0]   emitted_inc;
    logic [RING_AW-1:0] rd_off;
    logic               written_now;

    assign o_free       = !m_valid_reg || m_ready;
    assign emit_byte    = d_hit_reg ? d_hit_data_reg :
                          (d_written_reg ? mem_rdata_reg : d_dflt_reg);
    assign emit         = (st_reg == ST_RUN) && d_valid_reg && o_free;
    assign emitted_inc  = emitted_reg + CNT_W'(1);
    assign done         = (emitted_inc >= limit);
    assign issue        = (st_reg == ST_RUN) && (left_reg != '0) &&
                          (!d_valid_reg || emit) && !(emit && done);
    assign precheck_fin = finished_reg || (emitted_reg >= limit);

    // An entry counts as written once the cursor has passed it since restart
    assign rd_off      = rd_addr_reg - RING_START;
    assign written_now = fill_reg[FILL_W-1] || ({1'b0, rd_off} < fill_reg);

    always_comb begin
        st_next         = st_reg;
        lit_next        = lit_reg;
        lit_byte_next   = lit_byte_reg;
        rd_addr_next    = rd_addr_reg;
        left_next       = left_reg;
        eoi_next        = eoi_reg;
        d_valid_next    = d_valid_reg;
        d_last_next     = d_last_reg;
        d_hit_next      = d_hit_reg;
        d_hit_data_next = d_hit_data_reg;
        d_written_next  = d_written_reg;
        d_dflt_next     = d_dflt_reg;
        cursor_next     = cursor_reg;
        fill_next       = fill_reg;
        emitted_next    = emitted_reg;
        finished_next   = finished_reg;
        m_valid_next    = m_valid_reg;
        m_data_next     = m_data_reg;
        cmd_pop         = 1'b0;
        err_load        = 1'b0;

        // Drain the output register
        if (m_ready) begin
            m_valid_next = 1'b0;
        end

        case (st_reg)
            ST_IDLE: begin
                if (!cmd_empty) begin
                    cmd_pop = 1'b1;
                    if (precheck_fin) begin
                        finished_next = 1'b1;
                    end
                    if ((cmd.kind != CMD_NONE) && !precheck_fin) begin
                        lit_next      = (cmd.kind == CMD_LIT);
                        lit_byte_next = cmd.data;
                        rd_addr_next  = cmd.pos;
                        left_next     = cmd.len;
                        eoi_next      = cmd.eoi;
                        st_next       = ST_RUN;
                    end else if (cmd.eoi) begin
                        if (precheck_fin) begin
                            cursor_next   = RING_START;
                            fill_next     = '0;
                            emitted_next  = '0;
                            finished_next = 1'b0;
                        end else begin
                            st_next = ST_ERR;
                        end
                    end
                end
            end
            ST_RUN: begin
                // Emit the byte in the data stage and write it to the ring
                if (emit) begin
                    cursor_next  = cursor_reg + RING_AW'(1);
                    fill_next    = fill_reg[FILL_W-1] ? fill_reg : fill_reg + FILL_W'(1);
                    emitted_next = emitted_inc;
                    if (done) begin
                        finished_next = 1'b1;
                    end
                    m_valid_next            = 1'b1;
                    m_data_next.out_byte    = emit_byte;
                    m_data_next.run_last    = done || (d_last_reg && !eoi_reg);
                    m_data_next.stream_done = done;
                    m_data_next.status      = 1'b0;
                end
                // Issue the next ring read, forwarding a byte written this cycle
                if (issue) begin
                    d_valid_next    = 1'b1;
                    d_last_next     = (left_reg == LEN_W'(1));
                    d_hit_next      = lit_reg || (emit && (rd_addr_reg == cursor_reg));
                    d_hit_data_next = lit_reg ? lit_byte_reg : emit_byte;
                    d_written_next  = written_now;
                    d_dflt_next     = (rd_addr_reg >= RING_START) ? ZERO_BYTE : SPACE_BYTE;
                    rd_addr_next    = rd_addr_reg + RING_AW'(1);
                    left_next       = left_reg - LEN_W'(1);
                end else if (emit) begin
                    d_valid_next = 1'b0;
                end
                // Close the token on its last byte or when the size is reached
                if (emit && (done || d_last_reg)) begin
                    d_valid_next = 1'b0;
                    left_next    = '0;
                    st_next      = ST_IDLE;
                    if (eoi_reg) begin
                        if (done) begin
                            cursor_next   = RING_START;
                            fill_next     = '0;
                            emitted_next  = '0;
                            finished_next = 1'b0;
                        end else begin
                            st_next = ST_ERR;
                        end
                    end
                end
            end
            ST_ERR: begin
                // Report truncation and restart the stream
                if (o_free) begin
                    err_load                = 1'b1;
                    m_valid_next            = 1'b1;
                    m_data_next.out_byte    = 8'd0;
                    m_data_next.run_last    = 1'b1;
                    m_data_next.stream_done = 1'b0;
                    m_data_next.status      = 1'b1;
                    cursor_next             = RING_START;
                    fill_next               = '0;
                    emitted_next            = '0;
                    finished_next           = 1'b0;
                    st_next                 = ST_IDLE;
                end
            end
            default: begin
                st_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg       <= ST_IDLE;
            left_reg     <= '0;
            d_valid_reg  <= 1'b0;
            cursor_reg   <= RING_START;
            fill_reg     <= '0;
            emitted_reg  <= '0;
            finished_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            st_reg       <= st_next;
            left_reg     <= left_next;
            d_valid_reg  <= d_valid_next;
            cursor_reg   <= cursor_next;
            fill_reg     <= fill_next;
            emitted_reg  <= emitted_next;
            finished_reg <= finished_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Hold token and data-stage payload
    always_ff @(posedge aclk) begin
        lit_reg        <= lit_next;
        lit_byte_reg   <= lit_byte_next;
        rd_addr_reg    <= rd_addr_next;
        eoi_reg        <= eoi_next;
        d_last_reg     <= d_last_next;
        d_hit_reg      <= d_hit_next;
        d_hit_data_reg <= d_hit_data_next;
        d_written_reg  <= d_written_next;
        d_dflt_reg     <= d_dflt_next;
        m_data_reg     <= m_data_next;
    end

    // Ring port: write at the cursor, registered read at the copy address
    always_ff @(posedge aclk) begin
        if (emit) begin
            ring_mem[cursor_reg] <= emit_byte;
        end
        if (issue) begin
            mem_rdata_reg <= ring_mem[rd_addr_reg];
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign stat.idle     = (st_reg == ST_IDLE);
    assign stat.err_load = err_load;
    assign stat.fresh    = (emitted_reg == '0) && !finished_reg && (cursor_reg == RING_START);

endmodule

// File: hdl/lzss_decompressor.sv
// Channel   Ports                        Moves per transfer
// input     s_valid s_ready s_data       one compressed byte and its end-of-input mark
// result    m_valid m_ready m_data       one output byte or a truncation report
// config    cfg_wr_en cfg_wr_data        output size
//
// Input bytes enter a four-entry command queue at one per cycle; the parser never waits
// on the expander except when that queue is full.
// The expander handles tokens of L output bytes (L = 1 for a literal, 3 to 18 for a match);
// within a token it emits one byte per cycle while the result channel accepts them.
// A truncation report is sent from its own error state. No clearing pass: a fill count marks
// ring entries written since the stream restarted, so the block is ready right after reset.
// Either side may stall at any time; the result register holds until transferred.
module lzss_decompressor (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  lzss_pkg::in_item_t            s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output lzss_pkg::out_item_t           m_data,
    input  logic                          cfg_wr_en,
    input  logic [lzss_pkg::CNT_W-1:0]    cfg_wr_data
);
    import lzss_pkg::*;

    logic [CNT_W-1:0] output_size_reg;
    logic [CNT_W-1:0] limit;
    logic             fifo_push;
    logic             fifo_full;
    logic             fifo_pop;
    logic             fifo_empty;
    cmd_t             push_cmd;
    cmd_t             pop_cmd;
    back_stat_t       bk_stat;

    // Hold the configured size
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            output_size_reg <= '0;
        end else if (cfg_wr_en) begin
            output_size_reg <= cfg_wr_data;
        end
    end

    // Saturate the size
    assign limit = (output_size_reg > SIZE_CAP) ? SIZE_CAP : output_size_reg;

    lzss_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .cmd_push  (fifo_push),
        .cmd       (push_cmd),
        .fifo_full (fifo_full)
    );

    lzss_cmd_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (fifo_push),
        .push_cmd (push_cmd),
        .full     (fifo_full),
        .pop      (fifo_pop),
        .pop_cmd  (pop_cmd),
        .empty    (fifo_empty)
    );

    lzss_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .limit     (limit),
        .cmd_empty (fifo_empty),
        .cmd       (pop_cmd),
        .cmd_pop   (fifo_pop),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .stat      (bk_stat)
    );

    // The parser never pushes into a full queue
    a_no_push_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        fifo_push |-> !fifo_full)
        else $error("command pushed into full queue");

    // A truncation report leaves a fresh stream behind it
    a_err_restarts: assert property (@(posedge aclk) disable iff (!aresetn)
        bk_stat.err_load |=> (bk_stat.fresh && bk_stat.idle))
        else $error("stream not restarted after truncation report");

    // The expander only pops while idle
    a_pop_when_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        fifo_pop |-> (bk_stat.idle && !fifo_empty))
        else $error("command popped outside idle");

    // Reset empties the result register
    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

endmodule
